// File: rtl/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the HSV to RGB444 converter.
// No dependencies; every other file of the block imports this package.
package hsv2rgb_pkg;

    localparam int unsigned Q_W    = 9;
    localparam int unsigned CHAN_W = 4;

    localparam logic [Q_W-1:0] Q_ONE = 9'd256;

    // Hue sector, the integer part of hue times six.
    typedef enum logic [2:0] {
        SECTOR_0 = 3'd0,
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5
    } sector_t;

    // Clamp a Q1.8 value to 1.0.
    function automatic logic [Q_W-1:0] sat_q18(input logic [Q_W-1:0] x);
        return (x > Q_ONE) ? Q_ONE : x;
    endfunction

    // (15 * x) >> 8 for a clamped Q1.8 value; the result always fits in a channel.
    function automatic logic [CHAN_W-1:0] scale15_q8(input logic [Q_W-1:0] x);
        logic [Q_W+3:0] m;
        m = {x, 4'b0000} - {4'b0000, x};
        return m[Q_W+2:Q_W-1];
    endfunction

endpackage

// File: rtl/hsv2rgb_prep.sv
`timescale 1ns / 1ps
// First stage: clamps Q1.8 inputs, splits hue to sector and fraction, scales value, alpha.
// Depends on hsv2rgb_pkg.
module hsv2rgb_prep #(
    parameter int unsigned HUE_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [15:0]                  in_hue,
    input  logic [hsv2rgb_pkg::Q_W-1:0]  in_sat,
    input  logic [hsv2rgb_pkg::Q_W-1:0]  in_val,
    input  logic [hsv2rgb_pkg::Q_W-1:0]  in_alpha,
    output logic                         out_valid,
    input  logic                         out_ready,
    output hsv2rgb_pkg::sector_t         out_sector,
    output logic [HUE_BITS-1:0]          out_frac,
    output logic [hsv2rgb_pkg::Q_W-1:0]  out_sat,
    output logic [hsv2rgb_pkg::Q_W-1:0]  out_val,
    output logic [hsv2rgb_pkg::CHAN_W-1:0] out_vv,
    output logic [hsv2rgb_pkg::CHAN_W-1:0] out_aa
);
    import hsv2rgb_pkg::*;

    logic [HUE_BITS-1:0]   hue_w;
    logic [HUE_BITS+2:0]   hue6;
    logic [Q_W-1:0]        sat_c;
    logic [Q_W-1:0]        val_c;

    logic                  valid_reg;
    sector_t               sector_reg;
    logic [HUE_BITS-1:0]   frac_reg;
    logic [Q_W-1:0]        sat_reg;
    logic [Q_W-1:0]        val_reg;
    logic [CHAN_W-1:0]     vv_reg;
    logic [CHAN_W-1:0]     aa_reg;

    // Hue bits above HUE_BITS are dropped, so the hue wraps at a full turn.
    generate
        if (HUE_BITS <= 16) begin : g_hue_trunc
            assign hue_w = in_hue[HUE_BITS-1:0];
        end else begin : g_hue_ext
            assign hue_w = {{(HUE_BITS-16){1'b0}}, in_hue};
        end
    endgenerate

    assign hue6  = {1'b0, hue_w, 2'b00} + {2'b00, hue_w, 1'b0};
    assign sat_c = sat_q18(in_sat);
    assign val_c = sat_q18(in_val);

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sector_reg <= sector_t'(hue6[HUE_BITS+2:HUE_BITS]);
            frac_reg   <= hue6[HUE_BITS-1:0];
            sat_reg    <= sat_c;
            val_reg    <= val_c;
            vv_reg     <= scale15_q8(val_c);
            aa_reg     <= scale15_q8(sat_q18(in_alpha));
        end
    end

    assign out_sector = sector_reg;
    assign out_frac   = frac_reg;
    assign out_sat    = sat_reg;
    assign out_val    = val_reg;
    assign out_vv     = vv_reg;
    assign out_aa     = aa_reg;

endmodule

// File: rtl/hsv2rgb_blend.sv
`timescale 1ns / 1ps
// Second pipeline stage: forms the p, q and t blend factors from fraction and saturation.
// Depends on hsv2rgb_pkg.
module hsv2rgb_blend #(
    parameter int unsigned HUE_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  hsv2rgb_pkg::sector_t           in_sector,
    input  logic [HUE_BITS-1:0]            in_frac,
    input  logic [hsv2rgb_pkg::Q_W-1:0]    in_sat,
    input  logic [hsv2rgb_pkg::Q_W-1:0]    in_val,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0] in_vv,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0] in_aa,
    output logic                           out_valid,
    input  logic                           out_ready,
    output hsv2rgb_pkg::sector_t           out_sector,
    output logic [hsv2rgb_pkg::Q_W-1:0]    out_val,
    output logic [hsv2rgb_pkg::CHAN_W-1:0] out_vv,
    output logic [hsv2rgb_pkg::CHAN_W-1:0] out_aa,
    output logic [hsv2rgb_pkg::Q_W-1:0]    out_pb,
    output logic [HUE_BITS+8:0]            out_qb,
    output logic [HUE_BITS+8:0]            out_tb
);
    import hsv2rgb_pkg::*;

    localparam int unsigned BW = HUE_BITS + Q_W;

    logic [BW-1:0]     fs;
    logic [Q_W-1:0]    one_minus_s;

    logic              valid_reg;
    sector_t           sector_reg;
    logic [Q_W-1:0]    val_reg;
    logic [CHAN_W-1:0] vv_reg;
    logic [CHAN_W-1:0] aa_reg;
    logic [Q_W-1:0]    pb_reg;
    logic [BW-1:0]     qb_reg;
    logic [BW-1:0]     tb_reg;

    assign fs          = {{Q_W{1'b0}}, in_frac} * {{HUE_BITS{1'b0}}, in_sat};
    assign one_minus_s = Q_ONE - in_sat;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // q = 1 - f*s and t = 1 - (1-f)*s = (1-s) + f*s, both at HUE_BITS+8 fraction bits.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sector_reg <= in_sector;
            val_reg    <= in_val;
            vv_reg     <= in_vv;
            aa_reg     <= in_aa;
            pb_reg     <= one_minus_s;
            qb_reg     <= {Q_ONE, {HUE_BITS{1'b0}}} - fs;
            tb_reg     <= {one_minus_s, {HUE_BITS{1'b0}}} + fs;
        end
    end

    assign out_sector = sector_reg;
    assign out_val    = val_reg;
    assign out_vv     = vv_reg;
    assign out_aa     = aa_reg;
    assign out_pb     = pb_reg;
    assign out_qb     = qb_reg;
    assign out_tb     = tb_reg;

endmodule

// File: rtl/hsv2rgb_mult.sv
`timescale 1ns / 1ps
// Third pipeline stage: multiplies the value into each blend factor.
// Depends on hsv2rgb_pkg.
module hsv2rgb_mult #(
    parameter int unsigned HUE_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  hsv2rgb_pkg::sector_t           in_sector,
    input  logic [hsv2rgb_pkg::Q_W-1:0]    in_val,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0] in_vv,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0] in_aa,
    input  logic [hsv2rgb_pkg::Q_W-1:0]    in_pb,
    input  logic [HUE_BITS+8:0]            in_qb,
    input  logic [HUE_BITS+8:0]            in_tb,
    output logic                           out_valid,
    input  logic                           out_ready,
    output hsv2rgb_pkg::sector_t           out_sector,
    output logic [hsv2rgb_pkg::CHAN_W-1:0] out_vv,
    output logic [hsv2rgb_pkg::CHAN_W-1:0] out_aa,
    output logic [17:0]                    out_pm,
    output logic [HUE_BITS+17:0]           out_qm,
    output logic [HUE_BITS+17:0]           out_tm
);
    import hsv2rgb_pkg::*;

    localparam int unsigned MW = HUE_BITS + 2 * Q_W;

    logic [MW-1:0]     val_ext;

    logic              valid_reg;
    sector_t           sector_reg;
    logic [CHAN_W-1:0] vv_reg;
    logic [CHAN_W-1:0] aa_reg;
    logic [17:0]       pm_reg;
    logic [MW-1:0]     qm_reg;
    logic [MW-1:0]     tm_reg;

    assign val_ext = {{(HUE_BITS+Q_W){1'b0}}, in_val};

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sector_reg <= in_sector;
            vv_reg     <= in_vv;
            aa_reg     <= in_aa;
            pm_reg     <= {{Q_W{1'b0}}, in_val} * {{Q_W{1'b0}}, in_pb};
            qm_reg     <= val_ext * {{Q_W{1'b0}}, in_qb};
            tm_reg     <= val_ext * {{Q_W{1'b0}}, in_tb};
        end
    end

    assign out_sector = sector_reg;
    assign out_vv     = vv_reg;
    assign out_aa     = aa_reg;
    assign out_pm     = pm_reg;
    assign out_qm     = qm_reg;
    assign out_tm     = tm_reg;

endmodule

// File: rtl/hsv2rgb_pack.sv
`timescale 1ns / 1ps
// Last pipeline stage: scales by 15, truncates to 4-bit channels and packs the pixel.
// Depends on hsv2rgb_pkg; its register is the output register of the block.
module hsv2rgb_pack #(
    parameter int unsigned HUE_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  hsv2rgb_pkg::sector_t           in_sector,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0] in_vv,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0] in_aa,
    input  logic [17:0]                    in_pm,
    input  logic [HUE_BITS+17:0]           in_qm,
    input  logic [HUE_BITS+17:0]           in_tm,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [15:0]                    out_color
);
    import hsv2rgb_pkg::*;

    localparam int unsigned MW = HUE_BITS + 18;

    logic [21:0]       p15;
    logic [MW+3:0]     q15;
    logic [MW+3:0]     t15;
    logic [CHAN_W-1:0] p_ch;
    logic [CHAN_W-1:0] q_ch;
    logic [CHAN_W-1:0] t_ch;
    logic [CHAN_W-1:0] r_ch;
    logic [CHAN_W-1:0] g_ch;
    logic [CHAN_W-1:0] b_ch;

    logic              valid_reg;
    logic [15:0]       color_reg;

    // Times 15 as x*16 - x; the channel is the nibble just above the fraction bits.
    assign p15  = {in_pm, 4'b0000} - {4'b0000, in_pm};
    assign q15  = {in_qm, 4'b0000} - {4'b0000, in_qm};
    assign t15  = {in_tm, 4'b0000} - {4'b0000, in_tm};
    assign p_ch = p15[19:16];
    assign q_ch = q15[HUE_BITS+19:HUE_BITS+16];
    assign t_ch = t15[HUE_BITS+19:HUE_BITS+16];

    always_comb begin
        unique case (in_sector)
            SECTOR_0: begin
                r_ch = in_vv; g_ch = t_ch;  b_ch = p_ch;
            end
            SECTOR_1: begin
                r_ch = q_ch;  g_ch = in_vv; b_ch = p_ch;
            end
            SECTOR_2: begin
                r_ch = p_ch;  g_ch = in_vv; b_ch = t_ch;
            end
            SECTOR_3: begin
                r_ch = p_ch;  g_ch = q_ch;  b_ch = in_vv;
            end
            SECTOR_4: begin
                r_ch = t_ch;  g_ch = p_ch;  b_ch = in_vv;
            end
            default: begin
                r_ch = in_vv; g_ch = p_ch;  b_ch = q_ch;
            end
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            color_reg <= {g_ch, b_ch, in_aa, r_ch};
        end
    end

    assign out_color = color_reg;

endmodule

// File: rtl/hsv_to_rgb444.sv
`timescale 1ns / 1ps
// Top level of the HSV to RGB444 converter: four pipeline stages behind stream handshakes.
// Depends on hsv2rgb_pkg, hsv2rgb_prep, hsv2rgb_blend, hsv2rgb_mult and hsv2rgb_pack.

// The converter takes one pixel per clock while the output is not stalled, passing it
// through four register stages: hue split and input clamping, the blend
// factors (one fraction-by-saturation multiply), the value multiplies, and scaling and
// channel packing into the output register. Each stage holds its transaction while the
// one after it is stalled, so back-pressure on the output stops the pipeline stage by
// stage and fills any bubbles first; s_tready stays high whenever the output register is
// empty or being read. HUE_BITS sets how many low bits of the hue form one full turn.
module hsv_to_rgb444 #(
    parameter int unsigned HUE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] hue, [24:16] saturation, [33:25] brightness, [42:34] alpha, [47:43] zero
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] packed_color
    output logic [15:0] m_tdata
);
    import hsv2rgb_pkg::*;

    logic                prep_valid;
    logic                prep_ready;
    sector_t             prep_sector;
    logic [HUE_BITS-1:0] prep_frac;
    logic [Q_W-1:0]      prep_sat;
    logic [Q_W-1:0]      prep_val;
    logic [CHAN_W-1:0]   prep_vv;
    logic [CHAN_W-1:0]   prep_aa;

    logic                blend_valid;
    logic                blend_ready;
    sector_t             blend_sector;
    logic [Q_W-1:0]      blend_val;
    logic [CHAN_W-1:0]   blend_vv;
    logic [CHAN_W-1:0]   blend_aa;
    logic [Q_W-1:0]      blend_pb;
    logic [HUE_BITS+8:0] blend_qb;
    logic [HUE_BITS+8:0] blend_tb;

    logic                 mult_valid;
    logic                 mult_ready;
    sector_t              mult_sector;
    logic [CHAN_W-1:0]    mult_vv;
    logic [CHAN_W-1:0]    mult_aa;
    logic [17:0]          mult_pm;
    logic [HUE_BITS+17:0] mult_qm;
    logic [HUE_BITS+17:0] mult_tm;

    hsv2rgb_prep #(.HUE_BITS(HUE_BITS)) u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_hue     (s_tdata[15:0]),
        .in_sat     (s_tdata[24:16]),
        .in_val     (s_tdata[33:25]),
        .in_alpha   (s_tdata[42:34]),
        .out_valid  (prep_valid),
        .out_ready  (prep_ready),
        .out_sector (prep_sector),
        .out_frac   (prep_frac),
        .out_sat    (prep_sat),
        .out_val    (prep_val),
        .out_vv     (prep_vv),
        .out_aa     (prep_aa)
    );

    hsv2rgb_blend #(.HUE_BITS(HUE_BITS)) u_blend (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (prep_valid),
        .in_ready   (prep_ready),
        .in_sector  (prep_sector),
        .in_frac    (prep_frac),
        .in_sat     (prep_sat),
        .in_val     (prep_val),
        .in_vv      (prep_vv),
        .in_aa      (prep_aa),
        .out_valid  (blend_valid),
        .out_ready  (blend_ready),
        .out_sector (blend_sector),
        .out_val    (blend_val),
        .out_vv     (blend_vv),
        .out_aa     (blend_aa),
        .out_pb     (blend_pb),
        .out_qb     (blend_qb),
        .out_tb     (blend_tb)
    );

    hsv2rgb_mult #(.HUE_BITS(HUE_BITS)) u_mult (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (blend_valid),
        .in_ready   (blend_ready),
        .in_sector  (blend_sector),
        .in_val     (blend_val),
        .in_vv      (blend_vv),
        .in_aa      (blend_aa),
        .in_pb      (blend_pb),
        .in_qb      (blend_qb),
        .in_tb      (blend_tb),
        .out_valid  (mult_valid),
        .out_ready  (mult_ready),
        .out_sector (mult_sector),
        .out_vv     (mult_vv),
        .out_aa     (mult_aa),
        .out_pm     (mult_pm),
        .out_qm     (mult_qm),
        .out_tm     (mult_tm)
    );

    hsv2rgb_pack #(.HUE_BITS(HUE_BITS)) u_pack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (mult_valid),
        .in_ready   (mult_ready),
        .in_sector  (mult_sector),
        .in_vv      (mult_vv),
        .in_aa      (mult_aa),
        .in_pm      (mult_pm),
        .in_qm      (mult_qm),
        .in_tm      (mult_tm),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_color  (m_tdata)
    );

`ifndef ASSERT_OFF
    // The pipeline only pushes back when a result is waiting in the output register.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tready || !m_tvalid) |-> s_tready)
        else $error("input stalled although the output register can move");

    // Reset empties the whole pipeline.
    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result presented right after reset");

    // With the output drained every cycle, an input transaction moves through without a stall and shows up.
    a_fixed_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(s_tvalid && s_tready, 4) && $past(m_tready, 1) && $past(m_tready, 2)
         && $past(m_tready, 3) && $past(aresetn, 1) && $past(aresetn, 2)
         && $past(aresetn, 3) && $past(aresetn, 4)) |-> m_tvalid)
        else $error("transaction lost in a free-running pipeline");
`endif

endmodule

// File: dv/tb_hsv_to_rgb444.sv
`timescale 1ns / 1ps
// Testbench for hsv_to_rgb444: directed corners, random pixels under varying idle mixes, then a long output stall.
// Depends on hsv2rgb_pkg and the hsv_to_rgb444 RTL; predicts each pixel in integer fixed point.
module tb_hsv_to_rgb444;
    import hsv2rgb_pkg::*;

    localparam int unsigned HUE_BITS      = 16;
    localparam int unsigned STALL_LIMIT   = 3000;
    localparam int unsigned DRAIN_CYCLES  = 12;
    localparam int unsigned LONG_HOLD     = 200;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [15:0] hue, [24:16] saturation, [33:25] brightness, [42:34] alpha, [47:43] zero
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [15:0] packed_color
    logic [15:0] m_tdata;

    logic [15:0] expected_pixels[$];
    int unsigned error_count   = 0;
    int unsigned pixels_sent   = 0;
    int unsigned pixels_seen   = 0;
    int unsigned tx_idle_pct   = 0;
    int unsigned rx_stall_pct  = 0;
    int unsigned idle_cycles   = 0;
    int unsigned rx_hold_left  = 0;
    bit          rx_hold_req   = 1'b0;

    hsv_to_rgb444 #(.HUE_BITS(HUE_BITS)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Q1.8 inputs above one are treated as exactly one.
    function automatic logic [63:0] clamp_unit(input logic [8:0] x);
        return (x > Q_ONE) ? 64'(Q_ONE) : 64'(x);
    endfunction

    function automatic logic [15:0] predict_rgb444(input logic [15:0] hue,
                                                   input logic [8:0]  sat_in,
                                                   input logic [8:0]  bri_in,
                                                   input logic [8:0]  alpha_in);
        logic [63:0] one_turn, h, s, v, a, h6, f, fone;
        logic [3:0]  vv, aa, p, q, t, r, g, b;
        sector_t     sector;
        one_turn = 64'd1 << HUE_BITS;
        h        = 64'(hue) & (one_turn - 64'd1);
        s        = clamp_unit(sat_in);
        v        = clamp_unit(bri_in);
        a        = clamp_unit(alpha_in);
        h6       = h * 64'd6;
        sector   = sector_t'(3'(h6 >> HUE_BITS));
        f        = h6 & (one_turn - 64'd1);
        fone     = one_turn << 8;
        vv       = 4'((64'd15 * v) >> 8);
        aa       = 4'((64'd15 * a) >> 8);
        p        = 4'((64'd15 * v * (64'(Q_ONE) - s)) >> 16);
        q        = 4'((64'd15 * v * (fone - f * s)) >> (HUE_BITS + 16));
        t        = 4'((64'd15 * v * (fone - (one_turn - f) * s)) >> (HUE_BITS + 16));
        case (sector)
            SECTOR_0: begin r = vv; g = t;  b = p;  end
            SECTOR_1: begin r = q;  g = vv; b = p;  end
            SECTOR_2: begin r = p;  g = vv; b = t;  end
            SECTOR_3: begin r = p;  g = q;  b = vv; end
            SECTOR_4: begin r = t;  g = p;  b = vv; end
            default: begin  r = vv; g = p;  b = q;  end
        endcase
        return {g, b, aa, r};
    endfunction

    // Mostly legal Q1.8 values, with a share of exact corners and of over-range codes.
    function automatic logic [8:0] random_q18();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            return ($urandom_range(1) != 0) ? Q_ONE : 9'd0;
        end else if (pick < 30) begin
            return 9'($urandom_range(511));
        end
        return 9'($urandom_range(256));
    endfunction

    // Offers one pixel and returns right after the edge that accepts it; s_tvalid stays high.
    task automatic send_pixel(input logic [15:0] hue, input logic [8:0] sat_in,
                              input logic [8:0] bri_in, input logic [8:0] alpha_in);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b00000, alpha_in, bri_in, sat_in, hue};
        expected_pixels.insert(expected_pixels.size(),
                               predict_rgb444(hue, sat_in, bri_in, alpha_in));
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
    endtask

    task automatic test_directed();
        logic [15:0] edge_hue;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_pixel(16'd0,     9'd0,   9'd0,   9'd0);
        send_pixel(16'hffff,  9'h1ff, 9'h1ff, 9'h1ff);
        send_pixel(16'd0,     Q_ONE,  Q_ONE,  Q_ONE);
        send_pixel(16'd32767, 9'd257, 9'd257, 9'd257);
        send_pixel(16'h5555,  9'd128, Q_ONE,  9'd17);
        send_pixel(16'haaaa,  Q_ONE,  9'd1,   9'd255);
        // Last hue of sectors 0 to 4 and the first hue of the next one.
        for (int k = 1; k < 6; k++) begin
            edge_hue = 16'(((k << HUE_BITS) + 5) / 6);
            send_pixel(edge_hue - 16'd1, Q_ONE, Q_ONE, 9'd128);
            send_pixel(edge_hue,         9'd200, Q_ONE, 9'd64);
        end
    endtask

    task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                       input int unsigned count);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) begin
            send_pixel(16'($urandom_range(65535)), random_q18(), random_q18(), random_q18());
        end
    endtask

    // The receiver stops for a long stretch while pixels keep coming, so the pipeline fills.
    task automatic test_output_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_req  = 1'b1;
        repeat (30) begin
            send_pixel(16'($urandom_range(65535)), random_q18(), random_q18(), random_q18());
        end
    endtask

    // Receiver side: random stalls, the long hold-off, and the result check.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                pixels_seen++;
                if (expected_pixels.size() == 0) begin
                    $error("packed_color %h arrived with no pixel pending", m_tdata);
                    error_count++;
                end else begin
                    if (m_tdata !== expected_pixels[0]) begin
                        $error("packed_color mismatch: expected %h, actual %h",
                               expected_pixels[0], m_tdata);
                        error_count++;
                    end
                    void'(expected_pixels.pop_front());
                end
            end
            if (rx_hold_req) begin
                rx_hold_req  = 1'b0;
                rx_hold_left = LONG_HOLD;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Ends the run when work is pending but no transaction has moved for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (!s_tvalid && expected_pixels.size() == 0)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_traffic(7, 59, 140);
        test_random_traffic(59, 7, 140);
        test_random_traffic(0, 0, 140);
        test_output_backpressure();
        s_tvalid <= 1'b0;

        wait (expected_pixels.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Converted %0d pixels, %0d checked: corner and over-range inputs,",
                 pixels_sent, pixels_seen);
        $display("every sector edge, random traffic under three idle mixes, a long output stall.");
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
